>>> rtl/integer_matrix_multiply_core_assert.svh
// ----------------------------------------------------------------------------
// integer matrix multiply assertion macros
// clocked assertion helpers used by the core, disabled during reset
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH

// same-cycle implication
`define IMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// integer matrix multiply package
// sizes, word types, codes and the control store of the sequencer
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int SUM_W  = 36;
  localparam int ADD_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
  localparam int CFG_W  = 4;
  localparam int STEP_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // register indexes
  localparam logic [1:0] CFG_A_ROWS = 2'd0;
  localparam logic [1:0] CFG_A_COLS = 2'd1;
  localparam logic [1:0] CFG_B_ROWS = 2'd2;
  localparam logic [1:0] CFG_B_COLS = 2'd3;

  // actions
  localparam logic [1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  // sequencer steps
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] STEP_START = 3'd2;
  localparam logic [STEP_W-1:0] STEP_RD    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MUL   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_ACC   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_NV    = 3'd7;

  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [35:0] product_value;
    logic               not_viable;
    logic               last_entry;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] a_rows;
    logic [CFG_W-1:0] a_cols;
    logic [CFG_W-1:0] b_rows;
    logic [CFG_W-1:0] b_cols;
  } cfg_dims_t;

  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic clr_ij;
    logic clr_acc;
    logic rd_en;
    logic mul_en;
    logic acc_en;
    logic step_ij;
  } imm_ctrl_t;

  typedef struct packed {
    logic k_more;
    logic entry_more;
  } imm_stat_t;

  typedef enum logic [2:0] {
    COND_ALWAYS     = 3'd0,
    COND_COMPUTE    = 3'd1,
    COND_MISMATCH   = 3'd2,
    COND_K_MORE     = 3'd3,
    COND_ENTRY_MORE = 3'd4
  } cond_t;

  typedef struct packed {
    logic              ready;
    logic              clr_ij;
    logic              clr_acc;
    logic              rd_en;
    logic              mul_en;
    logic              acc_en;
    logic              emit;
    logic              emit_nv;
    cond_t             cond;
    logic [STEP_W-1:0] jmp_true;
    logic [STEP_W-1:0] jmp_false;
  } ucode_t;

  // control store: one word per step
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    w.cond      = COND_ALWAYS;
    w.jmp_true  = STEP_IDLE;
    w.jmp_false = STEP_IDLE;
    case (step)
      STEP_IDLE: begin
        w.ready     = 1'b1;
        w.cond      = COND_COMPUTE;
        w.jmp_true  = STEP_CHECK;
        w.jmp_false = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.clr_ij    = 1'b1;
        w.cond      = COND_MISMATCH;
        w.jmp_true  = STEP_NV;
        w.jmp_false = STEP_START;
      end
      STEP_START: begin
        w.clr_acc  = 1'b1;
        w.jmp_true = STEP_RD;
      end
      STEP_RD: begin
        w.rd_en    = 1'b1;
        w.jmp_true = STEP_MUL;
      end
      STEP_MUL: begin
        w.mul_en   = 1'b1;
        w.jmp_true = STEP_ACC;
      end
      STEP_ACC: begin
        w.acc_en    = 1'b1;
        w.cond      = COND_K_MORE;
        w.jmp_true  = STEP_RD;
        w.jmp_false = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit      = 1'b1;
        w.cond      = COND_ENTRY_MORE;
        w.jmp_true  = STEP_START;
        w.jmp_false = STEP_IDLE;
      end
      STEP_NV: begin
        w.emit_nv  = 1'b1;
        w.jmp_true = STEP_IDLE;
      end
      default: begin
        w.jmp_true = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/imm_datapath.sv
// ----------------------------------------------------------------------------
// integer matrix multiply datapath
// element stores, index counters, multiplier and saturating accumulator
// ----------------------------------------------------------------------------
module imm_datapath import imm_pkg::*; (
  input  logic      clk,
  input  imm_ctrl_t ctrl,
  input  in_word_t  in_data,
  input  cfg_dims_t dims,
  output imm_stat_t stat,
  output out_word_t entry
);

  localparam logic signed [ADD_W-1:0] SAT_MAX =
    {{(ADD_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [ADD_W-1:0] SAT_MIN =
    {{(ADD_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) d = DIM_W'(1);
    else if (int'(r) > MAX_DIM) d = DIM_W'(MAX_DIM);
    else d = DIM_W'(r);
    return d;
  endfunction

  logic signed [ELEM_BITS-1:0] mem_a [0:DEPTH-1];
  logic signed [ELEM_BITS-1:0] mem_b [0:DEPTH-1];

  logic signed [ELEM_BITS-1:0] rd_a_r, rd_b_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [SUM_W-1:0]     acc_r, acc_nxt;
  logic [IDX_W-1:0]            i_r, j_r, k_r;

  logic [DIM_W-1:0]            rows, inner, cols;
  logic                        wr_ok;
  logic [ADDR_W-1:0]           wr_addr, rd_addr_a, rd_addr_b;
  logic signed [ELEM_BITS-1:0] wr_elem;
  logic signed [ADD_W-1:0]     sum;

  assign rows  = eff_dim(dims.a_rows);
  assign inner = eff_dim(dims.a_cols);
  assign cols  = eff_dim(dims.b_cols);

  assign wr_ok   = (int'(in_data.row_index) < MAX_DIM) && (int'(in_data.col_index) < MAX_DIM);
  assign wr_addr = ADDR_W'(int'(in_data.row_index) * MAX_DIM + int'(in_data.col_index));
  assign wr_elem = ELEM_BITS'(in_data.element_value);

  assign rd_addr_a = ADDR_W'(int'(i_r) * MAX_DIM + int'(k_r));
  assign rd_addr_b = ADDR_W'(int'(k_r) * MAX_DIM + int'(j_r));

  always_ff @(posedge clk) begin
    if (ctrl.ld_a && wr_ok) mem_a[wr_addr] <= wr_elem;
    if (ctrl.rd_en) rd_a_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_b && wr_ok) mem_b[wr_addr] <= wr_elem;
    if (ctrl.rd_en) rd_b_r <= mem_b[rd_addr_b];
  end

  // saturate at the signed bounds of the sum after every step
  always_comb begin
    sum = ADD_W'(acc_r) + ADD_W'(prod_r);
    if (sum > SAT_MAX) acc_nxt = SUM_W'(SAT_MAX);
    else if (sum < SAT_MIN) acc_nxt = SUM_W'(SAT_MIN);
    else acc_nxt = sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) prod_r <= PROD_W'(rd_a_r) * PROD_W'(rd_b_r);
    if (ctrl.clr_acc) begin
      acc_r <= '0;
      k_r   <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_nxt;
      k_r   <= k_r + IDX_W'(1);
    end
    if (ctrl.clr_ij) begin
      i_r <= '0;
      j_r <= '0;
    end else if (ctrl.step_ij) begin
      if (DIM_W'(j_r) + DIM_W'(1) == cols) begin
        j_r <= '0;
        i_r <= i_r + IDX_W'(1);
      end else begin
        j_r <= j_r + IDX_W'(1);
      end
    end
  end

  assign stat.k_more     = (DIM_W'(k_r) + DIM_W'(1)) != inner;
  assign stat.entry_more = !(((DIM_W'(i_r) + DIM_W'(1)) == rows) &&
                             ((DIM_W'(j_r) + DIM_W'(1)) == cols));

  assign entry.out_row       = 3'(i_r);
  assign entry.out_col       = 3'(j_r);
  assign entry.product_value = acc_r;
  assign entry.not_viable    = 1'b0;
  assign entry.last_entry    = !stat.entry_more;

endmodule

>>> rtl/integer_matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// integer matrix multiply core: a load word is written into its element store
// when accepted; a compute word runs a three-step read/multiply/accumulate loop
// per entry, or on a dimension mismatch gives a single not-viable word instead
// synchronous active-low reset: sequencer idle, output empty, dims back to 8
// ----------------------------------------------------------------------------
module integer_matrix_multiply_core import imm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // input words
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  // result words
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  // configuration writes
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

`include "integer_matrix_multiply_core_assert.svh"

  // sequencer state
  logic [STEP_W-1:0] step_r, step_nxt;
  ucode_t            uw;

  // configuration registers, raw values as written
  cfg_dims_t         cfg_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  // handshake and datapath control
  logic              accept;
  logic              compute_acc;
  logic              mismatch;
  logic              out_free;
  logic              stall;
  logic              fire_emit;
  logic              fire_nv;
  logic              cond_hit;
  imm_ctrl_t         ctrl;
  imm_stat_t         stat;
  out_word_t         entry;

  // current control word
  assign uw = ucode_rom(step_r);

  // only idle step takes words; loads complete in the cycle they arrive
  assign in_ready    = uw.ready;
  assign accept      = in_valid && in_ready;
  assign compute_acc = accept && (in_data.action == ACT_COMPUTE);

  // dimension test on the raw register values
  assign mismatch = cfg_r.a_cols != cfg_r.b_rows;

  // an emitting step waits until the output register can take a word
  assign out_free  = !out_valid_r || out_ready;
  assign stall     = (uw.emit || uw.emit_nv) && !out_free;
  assign fire_emit = uw.emit && out_free;
  assign fire_nv   = uw.emit_nv && out_free;

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:     cond_hit = 1'b1;
      COND_COMPUTE:    cond_hit = compute_acc;
      COND_MISMATCH:   cond_hit = mismatch;
      COND_K_MORE:     cond_hit = stat.k_more;
      COND_ENTRY_MORE: cond_hit = stat.entry_more;
      default:         cond_hit = 1'b0;
    endcase
  end

  // step counter with two-way branch, held while an emit is stalled
  always_comb begin
    if (stall) step_nxt = step_r;
    else if (cond_hit) step_nxt = uw.jmp_true;
    else step_nxt = uw.jmp_false;
  end

  always_comb begin
    ctrl.ld_a    = accept && (in_data.action == ACT_LOAD_A);
    ctrl.ld_b    = accept && (in_data.action == ACT_LOAD_B);
    ctrl.clr_ij  = uw.clr_ij;
    ctrl.clr_acc = uw.clr_acc;
    ctrl.rd_en   = uw.rd_en;
    ctrl.mul_en  = uw.mul_en;
    ctrl.acc_en  = uw.acc_en;
    ctrl.step_ij = fire_emit;
  end

  imm_datapath u_datapath (
    .clk     (clk),
    .ctrl    (ctrl),
    .in_data (in_data),
    .dims    (cfg_r),
    .stat    (stat),
    .entry   (entry)
  );

  // output register: loaded by an emitting step, drained by out_ready
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (fire_emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = entry;
    end else if (fire_nv) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      out_word_nxt.not_viable = 1'b1;
      out_word_nxt.last_entry = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload carries no reset
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // configuration writes, index beyond the list ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_rows <= CFG_RESET;
      cfg_r.a_cols <= CFG_RESET;
      cfg_r.b_rows <= CFG_RESET;
      cfg_r.b_cols <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_A_ROWS: cfg_r.a_rows <= cfg_wdata;
        CFG_A_COLS: cfg_r.a_cols <= cfg_wdata;
        CFG_B_ROWS: cfg_r.b_rows <= cfg_wdata;
        CFG_B_COLS: cfg_r.b_cols <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // a blocked emit holds the sequencer on its step
  `IMM_ASSERT_NEXT(a_emit_hold, (step_r == STEP_EMIT) && out_valid_r && !out_ready, step_r == STEP_EMIT, "emit step left while output blocked")
  // final entry returns the sequencer to idle
  `IMM_ASSERT_NEXT(a_last_idle, fire_emit && !stat.entry_more, (step_r == STEP_IDLE) && out_valid_r && out_word_r.last_entry, "final entry not followed by idle")
  // dimension mismatch goes straight to the not-viable step
  `IMM_ASSERT_NEXT(a_nv_branch, (step_r == STEP_CHECK) && mismatch, step_r == STEP_NV, "mismatch did not branch to not-viable")
  // a not-viable word is always a lone, zeroed, final word
  `IMM_ASSERT_NOW(a_nv_word, out_valid_r && out_word_r.not_viable, out_word_r.last_entry && (out_word_r.product_value == '0), "malformed not-viable word")

endmodule
